>>> hw/rtl/e2q_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared constants for the Euler-angle to quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int QUAT_BITS_DEF = 16;
    localparam int CORDIC_STEPS = 30;
    localparam int CW = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CW-1:0] PI_Q30 = 34'sd3373259426;

    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
        logic signed [CW-1:0] r;
        case (i)
            5'd0: r = 34'sd843314857;
            5'd1: r = 34'sd497837829;
            5'd2: r = 34'sd263043837;
            5'd3: r = 34'sd133525159;
            5'd4: r = 34'sd67021687;
            5'd5: r = 34'sd33543516;
            5'd6: r = 34'sd16775851;
            5'd7: r = 34'sd8388437;
            5'd8: r = 34'sd4194283;
            5'd9: r = 34'sd2097149;
            default: r = CW'(64'sd1 <<< (6'd30 - {1'b0, i}));
        endcase
        return r;
    endfunction
endpackage

>>> hw/rtl/e2q_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_if
// Valid/ready channel carrying a payload of parameterized type.
// ----------------------------------------------------------------------------
interface e2q_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/e2q_cordic_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_cordic_stage
// One registered group of CORDIC micro-rotations for a single angle.
// ----------------------------------------------------------------------------
module e2q_cordic_stage
    import e2q_pkg::*;
#(
    parameter int FIRST = 0,
    parameter int COUNT = 5
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [CW-1:0] z_in,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output logic signed [CW-1:0] z_out
);
    logic signed [CW-1:0] x_next, y_next, z_next;
    logic signed [CW-1:0] x_reg, y_reg, z_reg;

    always_comb
    begin
        logic signed [CW-1:0] dx, dy;
        x_next = x_in;
        y_next = y_in;
        z_next = z_in;
        for (int k = 0; k < COUNT; k++)
        begin
            dx = y_next >>> (FIRST + k);
            dy = x_next >>> (FIRST + k);
            if (!z_next[CW-1])
            begin
                x_next = x_next - dx;
                y_next = y_next + dy;
                z_next = z_next - atan_q30(5'(FIRST + k));
            end
            else
            begin
                x_next = x_next + dx;
                y_next = y_next - dy;
                z_next = z_next + atan_q30(5'(FIRST + k));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

>>> hw/rtl/e2q_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_sincos
// Pipelined half-angle sine and cosine: range fold, six CORDIC stages of
// five steps each, then the sign restore.
// ----------------------------------------------------------------------------
module e2q_sincos
    import e2q_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  logic                         clk,
    input  logic [7:0]                   en,
    input  logic signed [ANGLE_BITS-1:0] angle,
    output logic signed [CW-1:0]         sin_val,
    output logic signed [CW-1:0]         cos_val
);
    localparam int NST = 6;
    localparam int PER = CORDIC_STEPS / NST;

    logic signed [CW-1:0] h;
    logic signed [CW-1:0] z0_next, z0_reg;
    logic                 flip_next;
    logic [NST:0]         flip_reg;
    logic signed [CW-1:0] xs [NST+1];
    logic signed [CW-1:0] ys [NST+1];
    logic signed [CW-1:0] zs [NST+1];
    logic signed [CW-1:0] sin_reg, cos_reg;

    assign h = CW'(angle) <<< (32 - ANGLE_BITS);

    always_comb
    begin
        z0_next = h;
        flip_next = 1'b0;
        if (h > HALF_PI_Q30)
        begin
            z0_next = h - PI_Q30;
            flip_next = 1'b1;
        end
        else if (h < -HALF_PI_Q30)
        begin
            z0_next = h + PI_Q30;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            z0_reg <= z0_next;
            flip_reg[0] <= flip_next;
        end
        for (int s = 0; s < NST; s++)
        begin
            if (en[s+1])
            begin
                flip_reg[s+1] <= flip_reg[s];
            end
        end
    end

    assign xs[0] = CORDIC_GAIN;
    assign ys[0] = '0;
    assign zs[0] = z0_reg;

    for (genvar s = 0; s < NST; s++)
    begin : g_stage
        e2q_cordic_stage #(.FIRST(s * PER), .COUNT(PER)) u_stage (
            .clk   (clk),
            .en    (en[s+1]),
            .x_in  (xs[s]),
            .y_in  (ys[s]),
            .z_in  (zs[s]),
            .x_out (xs[s+1]),
            .y_out (ys[s+1]),
            .z_out (zs[s+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            sin_reg <= flip_reg[NST] ? -ys[NST] : ys[NST];
            cos_reg <= flip_reg[NST] ? -xs[NST] : xs[NST];
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;
endmodule

>>> hw/rtl/e2q_combine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_combine
// Two registered product layers forming the quaternion, then rounding and
// saturation to the output format.
// ----------------------------------------------------------------------------
module e2q_combine
    import e2q_pkg::*;
#(
    parameter int QUAT_BITS = QUAT_BITS_DEF
)
(
    input  logic                        clk,
    input  logic [2:0]                  en,
    input  logic signed [CW-1:0]        sr,
    input  logic signed [CW-1:0]        cr,
    input  logic signed [CW-1:0]        sp,
    input  logic signed [CW-1:0]        cp,
    input  logic signed [CW-1:0]        sy,
    input  logic signed [CW-1:0]        cy,
    output logic signed [QUAT_BITS-1:0] qw,
    output logic signed [QUAT_BITS-1:0] qx,
    output logic signed [QUAT_BITS-1:0] qy,
    output logic signed [QUAT_BITS-1:0] qz
);
    localparam int SH = 32 - QUAT_BITS;
    localparam int PW = 2 * CW;
    localparam logic signed [CW-1:0] ONE = CW'(64'sd1 <<< (QUAT_BITS - 2));

    logic signed [CW-1:0] crcp_reg, srsp_reg, srcp_reg, crsp_reg, sy_reg, cy_reg;
    logic signed [CW-1:0] w_reg, x_reg, y_reg, z_reg;
    logic signed [QUAT_BITS-1:0] qw_reg, qx_reg, qy_reg, qz_reg;

    function automatic logic signed [CW-1:0] qmul(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b);
        return CW'(p >>> 30);
    endfunction

    function automatic logic signed [QUAT_BITS-1:0] to_out(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        r = v;
        if (SH > 0)
        begin
            r = (v + CW'(64'sd1 <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
        end
        if (r > ONE)
        begin
            r = ONE;
        end
        if (r < -ONE)
        begin
            r = -ONE;
        end
        return r[QUAT_BITS-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            crcp_reg <= qmul(cr, cp);
            srsp_reg <= qmul(sr, sp);
            srcp_reg <= qmul(sr, cp);
            crsp_reg <= qmul(cr, sp);
            sy_reg <= sy;
            cy_reg <= cy;
        end
        if (en[1])
        begin
            w_reg <= qmul(crcp_reg, cy_reg) + qmul(srsp_reg, sy_reg);
            x_reg <= qmul(srcp_reg, cy_reg) - qmul(crsp_reg, sy_reg);
            y_reg <= qmul(crsp_reg, cy_reg) + qmul(srcp_reg, sy_reg);
            z_reg <= qmul(crcp_reg, sy_reg) - qmul(srsp_reg, cy_reg);
        end
        if (en[2])
        begin
            qw_reg <= to_out(w_reg);
            qx_reg <= to_out(x_reg);
            qy_reg <= to_out(y_reg);
            qz_reg <= to_out(z_reg);
        end
    end

    assign qw = qw_reg;
    assign qx = qx_reg;
    assign qy = qy_reg;
    assign qz = qz_reg;
endmodule

>>> hw/rtl/euler_to_quaternion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion
// ZYX Euler angles (Q2.13 radians) to a unit quaternion (Q1.14).
// ----------------------------------------------------------------------------
// The block accepts one transaction per clock cycle while its output is not
// stalled and passes it through a range fold, six CORDIC stages of five
// micro-rotations, a sign restore, two multiplier layers and a rounding
// stage. A stall on the output holds each occupied stage without a bubble
// ahead; a bubble is filled once it meets an occupied stage behind it.
module euler_to_quaternion
    import e2q_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int QUAT_BITS = QUAT_BITS_DEF
)
(
    input logic clk,
    input logic rst_n,
    e2q_if.sink   in_ch,
    e2q_if.source out_ch
);
    localparam int DEPTH = 11;

    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] en;
    logic signed [CW-1:0] sr, cr, sp, cp, sy, cy;
    logic signed [QUAT_BITS-1:0] qw, qx, qy, qz;

    always_comb
    begin
        en[DEPTH-1] = !vld_reg[DEPTH-1] || out_ch.ready;
        for (int i = DEPTH - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign in_ch.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_ch.valid;
            end
            for (int i = 1; i < DEPTH; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    e2q_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
        .clk (clk), .en (en[7:0]), .angle (in_ch.data.roll_angle),
        .sin_val (sr), .cos_val (cr)
    );
    e2q_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
        .clk (clk), .en (en[7:0]), .angle (in_ch.data.pitch_angle),
        .sin_val (sp), .cos_val (cp)
    );
    e2q_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
        .clk (clk), .en (en[7:0]), .angle (in_ch.data.yaw_angle),
        .sin_val (sy), .cos_val (cy)
    );

    e2q_combine #(.QUAT_BITS(QUAT_BITS)) u_combine (
        .clk (clk), .en (en[10:8]),
        .sr (sr), .cr (cr), .sp (sp), .cp (cp), .sy (sy), .cy (cy),
        .qw (qw), .qx (qx), .qy (qy), .qz (qz)
    );

    assign out_ch.valid = vld_reg[DEPTH-1];
    assign out_ch.data.quat_w = qw;
    assign out_ch.data.quat_x = qx;
    assign out_ch.data.quat_y = qy;
    assign out_ch.data.quat_z = qz;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(qw) && $stable(qz))
        else $error("Output result changed while stalled.");
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.ready |-> in_ch.ready)
        else $error("Input stalled although the output drains.");
    a_w_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> qw <= $signed(QUAT_BITS'(1 << (QUAT_BITS - 2)))
                      && qw >= -$signed(QUAT_BITS'(1 << (QUAT_BITS - 2))))
        else $error("Quaternion component beyond unit range.");
endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Euler-angle to quaternion pipeline.
// ----------------------------------------------------------------------------
// Queued angle triples are driven on the input channel with random gaps, and
// each one is scored against a bit-exact CORDIC model. Results are checked in
// order on the output channel while its ready is throttled at random. One long
// output stall fills the pipeline, and one input pause drains it. The first
// part of the input queue holds directed corner values and the rest is random.
// ----------------------------------------------------------------------------
module tb;
    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
    } angles_t;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } quat_t;

    localparam longint GAIN = 64'sd652032874;
    localparam longint HPI = 64'sd1686629713;
    localparam longint PI = 64'sd3373259426;
    localparam int N_RANDOM = 1380;
    localparam int TIMEOUT = 400000;
    localparam int DRAIN_AT = 600;
    localparam int HOLD_AT = 250;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    e2q_if #(.payload_t(angles_t)) in_ch();
    e2q_if #(.payload_t(quat_t)) out_ch();

    euler_to_quaternion i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    angles_t pending_angles[$];
    quat_t expected_quats[$];
    longint arctan_tab[30];
    int accepted_cnt = 0;
    int issued_cnt = 0;
    int result_cnt = 0;
    int mismatch_cnt = 0;
    int cycle_cnt = 0;
    int in_gap = 0;
    int out_gap = 0;
    int hold_cycles = 0;
    bit hold_done = 1'b0;
    bit drain_wait = 1'b0;
    bit drain_done = 1'b0;
    bit stim_done = 1'b0;

    initial
    begin
        arctan_tab = '{843314857, 497837829, 263043837, 133525159, 67021687,
                       33543516, 16775851, 8388437, 4194283, 2097149,
                       1048576, 524288, 262144, 131072, 65536, 32768, 16384,
                       8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8,
                       4, 2};
    end

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic longint qprod(longint a, longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic void half_sin_cos(input logic signed [15:0] ang,
                                         output longint sn, output longint cs);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit flip;
        z = longint'(ang) * 65536;
        x = GAIN;
        y = 0;
        flip = 1'b0;
        if (z > HPI)
        begin
            z = z - PI;
            flip = 1'b1;
        end
        else if (z < -HPI)
        begin
            z = z + PI;
            flip = 1'b1;
        end
        for (int i = 0; i < 30; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_tab[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_tab[i];
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endfunction

    function automatic logic signed [15:0] round_sat(longint v);
        longint r;
        r = (v + 64'sd32768) >>> 16;
        if (r > 16384)
            r = 16384;
        if (r < -16384)
            r = -16384;
        return r[15:0];
    endfunction

    function automatic quat_t zyx_quaternion(angles_t a);
        longint sr, cr, sp, cp, sy, cy;
        longint crcp, srsp, srcp, crsp;
        quat_t q;
        half_sin_cos(a.roll_angle, sr, cr);
        half_sin_cos(a.pitch_angle, sp, cp);
        half_sin_cos(a.yaw_angle, sy, cy);
        crcp = qprod(cr, cp);
        srsp = qprod(sr, sp);
        srcp = qprod(sr, cp);
        crsp = qprod(cr, sp);
        q.quat_w = round_sat(qprod(crcp, cy) + qprod(srsp, sy));
        q.quat_x = round_sat(qprod(srcp, cy) - qprod(crsp, sy));
        q.quat_y = round_sat(qprod(crsp, cy) + qprod(srcp, sy));
        q.quat_z = round_sat(qprod(crcp, sy) - qprod(srsp, cy));
        return q;
    endfunction

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($signed($urandom_range(0, 2000)) - 1000);
            2: return 16'($signed($urandom_range(25636, 25836))
                          * ($urandom_range(0, 1) ? 1 : -1));
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic signed [15:0] corners[12];
        angles_t a;
        corners = '{16'sd0, 16'sd32767, -16'sd32768, -16'sd32767, 16'sd1,
                    -16'sd1, 16'sd25735, 16'sd25736, 16'sd25737, -16'sd25736,
                    -16'sd25737, 16'sd12868};
        for (int i = 0; i < 12; i++)
        begin
            a.roll_angle = corners[i];
            a.pitch_angle = corners[(i + 3) % 12];
            a.yaw_angle = corners[(i + 7) % 12];
            pending_angles.push_back(a);
        end
        pending_angles.push_back('{16'sd32767, 16'sd32767, 16'sd32767});
        pending_angles.push_back('{-16'sd32768, -16'sd32768, -16'sd32768});
        pending_angles.push_back('{16'sd0, 16'sd0, 16'sd0});
        pending_angles.push_back('{16'sd12868, 16'sd12868, 16'sd12868});
        pending_angles.push_back('{-16'sd12868, 16'sd12868, -16'sd12868});
        pending_angles.push_back('{16'sd25736, 16'sd0, 16'sd0});
        pending_angles.push_back('{16'sd0, 16'sd25736, 16'sd0});
        pending_angles.push_back('{16'sd0, 16'sd0, 16'sd25736});
        pending_angles.push_back('{16'h5555, 16'hAAAA, 16'h5555});
        pending_angles.push_back('{16'hAAAA, 16'h5555, 16'hAAAA});
        for (int i = 0; i < N_RANDOM; i++)
        begin
            a.roll_angle = rand_angle();
            a.pitch_angle = rand_angle();
            a.yaw_angle = rand_angle();
            pending_angles.push_back(a);
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (stim_done && expected_quats.size() == 0);
        repeat (40) @(posedge clk);
        if (mismatch_cnt == 0 && expected_quats.size() == 0)
            $display("[euler_to_quaternion] OK");
        else
            $display("[euler_to_quaternion] ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_cnt <= cycle_cnt + 1;
            if (cycle_cnt >= TIMEOUT)
            begin
                $display("[euler_to_quaternion] ERROR");
                $finish;
            end
            if (in_ch.valid && in_ch.ready)
            begin
                expected_quats.push_back(zyx_quaternion(in_ch.data));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                result_cnt <= result_cnt + 1;
                if (expected_quats.size() == 0)
                begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10)
                        $display("unexpected transaction: %p", out_ch.data);
                end
                else
                begin
                    quat_t q;
                    q = expected_quats.pop_front();
                    if (q.quat_w !== out_ch.data.quat_w || q.quat_x !== out_ch.data.quat_x
                        || q.quat_y !== out_ch.data.quat_y
                        || q.quat_z !== out_ch.data.quat_z)
                    begin
                        mismatch_cnt <= mismatch_cnt + 1;
                        if (mismatch_cnt < 10)
                            $display("mismatch: expected %p, actual %p", q, out_ch.data);
                    end
                end
            end
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
        end
        else
        begin
            if (!in_ch.valid || accepted_cnt == issued_cnt)
            begin
                if (issued_cnt == DRAIN_AT && !drain_done)
                begin
                    drain_wait = 1'b1;
                    if (accepted_cnt == issued_cnt && expected_quats.size() == 0)
                        drain_done = 1'b1;
                end
                if (in_gap > 0)
                begin
                    in_ch.valid <= 1'b0;
                    in_gap = in_gap - 1;
                end
                else if (drain_wait && !drain_done)
                    in_ch.valid <= 1'b0;
                else if (pending_angles.size() > 0)
                begin
                    in_ch.data <= pending_angles.pop_front();
                    in_ch.valid <= 1'b1;
                    issued_cnt = issued_cnt + 1;
                    if (pending_angles.size() > 200 && $urandom_range(0, 9) == 0)
                        in_gap = $urandom_range(1, 18);
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                    stim_done = (accepted_cnt == issued_cnt);
                end
            end
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (!hold_done && result_cnt >= HOLD_AT)
            begin
                hold_cycles = hold_cycles + 1;
                if (hold_cycles > 80)
                    hold_done = 1'b1;
                out_ch.ready <= hold_done;
            end
            else if (out_gap > 0)
            begin
                out_ch.ready <= 1'b0;
                out_gap = out_gap - 1;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (pending_angles.size() > 200 && $urandom_range(0, 9) == 0)
                    out_gap = $urandom_range(1, 18);
            end
        end
    end
endmodule

>>> filelist.f
hw/rtl/e2q_pkg.sv
hw/rtl/e2q_if.sv
hw/rtl/e2q_cordic_stage.sv
hw/rtl/e2q_sincos.sv
hw/rtl/e2q_combine.sv
hw/rtl/euler_to_quaternion.sv
verif/tb.sv
